[design/fsa_pkg.sv]
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared constants and result codes for the first-fit suballocator.
// ----------------------------------------------------------------------------
package fsa_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int COUNT_BITS_DEF  = 24;

    localparam int EB_W     = 11;  // element_bytes width
    localparam int OFF_W    = 34;  // byte offset width
    localparam int STATUS_W = 3;
    localparam int TAG_W    = 2;
    localparam int CIDX_W   = 1;

    localparam logic [CIDX_W-1:0] CFG_CAPACITY = 1'd0;
    localparam logic [CIDX_W-1:0] CFG_ELEM_B   = 1'd1;

    localparam logic [EB_W-1:0] ELEM_B_RESET = 11'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVER_CAP  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_ENTRY = 3'd5;

endpackage

[design/fsa_mul.sv]
// ----------------------------------------------------------------------------
// fsa_mul
// Registered multiplier forming the byte offset from an element offset.
// ----------------------------------------------------------------------------
module fsa_mul
    import fsa_pkg::*;
#(
    parameter int A_W = COUNT_BITS_DEF,
    parameter int B_W = EB_W,
    parameter int P_W = OFF_W
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [A_W-1:0] i_a,
    input  logic [B_W-1:0] i_b,
    output logic [P_W-1:0] o_p
);

    localparam int F_W = (A_W + B_W > P_W) ? (A_W + B_W) : P_W;

    logic [F_W-1:0] w_a;
    logic [F_W-1:0] w_b;
    logic [F_W-1:0] w_full;
    logic [P_W-1:0] r_p;

    assign w_a    = F_W'(i_a);
    assign w_b    = F_W'(i_b);
    assign w_full = w_a * w_b;
    assign o_p    = r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_full[P_W-1:0];
        end
    end

endmodule

[design/first_fit_suballocator.sv]
// ----------------------------------------------------------------------------
// first_fit_suballocator
// Element-granular first-fit suballocator with reuse of freed table entries.
// ----------------------------------------------------------------------------
// Free and rejected commands go from the idle state straight to S_FIN.
// Allocate: the reuse search reads, fetches and checks each free-list slot,
// closing the list shifts each later slot down by one, then per sorted range
// one full pass runs over the entry table.
// One command at a time; in_stall is high until the result is registered.
// Synchronous active-low reset clears the in-use bits and counters and returns the config to its defaults.
module first_fit_suballocator
    import fsa_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    localparam int ID_W  = $clog2(MAX_ENTRIES),
    localparam int CFG_W = (COUNT_BITS > EB_W) ? COUNT_BITS : EB_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_command,
    input  logic [COUNT_BITS-1:0] i_elem_count,
    input  logic [TAG_W-1:0]    i_buffer_tag,
    input  logic [ID_W-1:0]     i_entry_id,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [TAG_W-1:0]    o_tag_out,
    output logic [ID_W-1:0]     o_entry_out,
    output logic [OFF_W-1:0]    o_offset_bytes,
    output logic [COUNT_BITS-1:0] o_count_out,
    output logic                o_reused,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int CW = COUNT_BITS;
    localparam int KW = 2 * CW + 1;   // sort key: {start, end}

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_FL_RD   = 4'd1;
    localparam logic [3:0] S_FL_E    = 4'd2;
    localparam logic [3:0] S_FL_CHK  = 4'd3;
    localparam logic [3:0] S_SHIFT   = 4'd4;
    localparam logic [3:0] S_SH_W    = 4'd5;
    localparam logic [3:0] S_GAP     = 4'd6;
    localparam logic [3:0] S_GAP_ST  = 4'd7;
    localparam logic [3:0] S_PLACE   = 4'd8;
    localparam logic [3:0] S_MUL     = 4'd9;
    localparam logic [3:0] S_MUL_W   = 4'd10;
    localparam logic [3:0] S_FIN     = 4'd11;

    logic [3:0]        r_state;
    logic [CW-1:0]     r_cap;
    logic [EB_W-1:0]   r_eb;

    logic              r_cmd;
    logic [CW-1:0]     r_cnt;
    logic [TAG_W-1:0]  r_tag;
    logic [STATUS_W-1:0] r_status;
    logic [ID_W-1:0]   r_ent;
    logic              r_reused;
    logic [CW-1:0]     r_off;

    logic [MAX_ENTRIES-1:0] r_in_use;
    logic [ID_W:0]     r_total;
    logic [ID_W:0]     r_ftotal;
    logic [ID_W:0]     r_k;
    logic [ID_W-1:0]   r_e;

    logic [ID_W:0]     r_i;
    logic              r_pv;
    logic [ID_W-1:0]   r_pidx;
    logic [CW:0]       r_cur;
    logic              r_have_last;
    logic [KW-1:0]     r_last;
    logic              r_found;
    logic [KW-1:0]     r_best;

    // table memories
    logic [CW-1:0]     m_off [MAX_ENTRIES];
    logic [CW-1:0]     m_size [MAX_ENTRIES];
    logic [ID_W-1:0]   m_fo [MAX_ENTRIES];
    logic [CW-1:0]     r_off_rd;
    logic [CW-1:0]     r_size_rd;
    logic [ID_W-1:0]   r_fo_rd;

    logic [ID_W-1:0]   w_ent_raddr;
    logic [ID_W-1:0]   w_fo_raddr;
    logic              w_ent_we;
    logic              w_fo_we;
    logic [ID_W-1:0]   w_fo_waddr;
    logic [ID_W-1:0]   w_fo_wdata;

    logic              w_in_xfer;
    logic              w_out_free;
    logic [ID_W:0]     w_k1;
    logic [KW-1:0]     w_key;
    logic [CW+1:0]     w_need_end;
    logic [CW+1:0]     w_best_s;
    logic [CW:0]       w_best_e;
    logic [OFF_W-1:0]  w_prod;
    logic              w_free_ok;
    logic              w_ok;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_out_free  = !o_out_valid || !i_out_stall;
    assign w_k1        = r_k + 1'b1;
    assign w_key       = {r_off_rd, ({1'b0, r_off_rd} + {1'b0, r_size_rd})};
    assign w_best_s    = (CW+2)'(r_best[KW-1:CW+1]);
    assign w_best_e    = r_best[CW:0];
    assign w_need_end  = (CW+2)'(r_cur) + (CW+2)'(r_cnt);
    assign w_free_ok   = ((ID_W+1)'(i_entry_id) < r_total) && r_in_use[i_entry_id]
                         && (r_ftotal < (ID_W+1)'(MAX_ENTRIES));
    assign w_ok        = (r_status == ST_OK);

    assign w_ent_raddr = (r_state == S_FL_E) ? r_fo_rd : r_i[ID_W-1:0];
    assign w_fo_raddr  = (r_state == S_SHIFT) ? w_k1[ID_W-1:0] : r_k[ID_W-1:0];
    assign w_ent_we    = (r_state == S_PLACE) && ((CW+2)'(r_cap) >= w_need_end);
    assign w_fo_we     = ((r_state == S_IDLE) && w_in_xfer && (i_command == CMD_FREE)
                          && w_free_ok) || (r_state == S_SH_W);
    assign w_fo_waddr  = (r_state == S_SH_W) ? r_k[ID_W-1:0] : r_ftotal[ID_W-1:0];
    assign w_fo_wdata  = (r_state == S_SH_W) ? r_fo_rd : i_entry_id;

    always_ff @(posedge i_clk) begin
        if (w_ent_we) begin
            m_off[r_total[ID_W-1:0]]  <= r_cur[CW-1:0];
            m_size[r_total[ID_W-1:0]] <= r_cnt;
        end
        r_off_rd  <= m_off[w_ent_raddr];
        r_size_rd <= m_size[w_ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_fo_we) begin
            m_fo[w_fo_waddr] <= w_fo_wdata;
        end
        r_fo_rd <= m_fo[w_fo_raddr];
    end

    fsa_mul #(
        .A_W (CW),
        .B_W (EB_W),
        .P_W (OFF_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (r_state == S_MUL),
        .i_a   (r_off),
        .i_b   (r_eb),
        .o_p   (w_prod)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CW'(65536);
            r_eb  <= ELEM_B_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_CAPACITY) begin
                r_cap <= i_cfg_data[CW-1:0];
            end else if (i_cfg_index == CFG_ELEM_B) begin
                r_eb <= i_cfg_data[EB_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cmd <= i_command;
            r_cnt <= i_elem_count;
            r_tag <= i_buffer_tag;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_use    <= '0;
            r_total     <= '0;
            r_ftotal    <= '0;
            r_pv        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_reused <= 1'b0;
                        r_k      <= '0;
                        if (i_command == CMD_FREE) begin
                            r_ent   <= i_entry_id;
                            r_state <= S_FIN;
                            if (w_free_ok) begin
                                r_in_use[i_entry_id] <= 1'b0;
                                r_ftotal <= r_ftotal + 1'b1;
                                r_status <= ST_OK;
                            end else begin
                                r_status <= ST_BAD_ENTRY;
                            end
                        end else if (i_elem_count == '0) begin
                            r_status <= ST_ZERO;
                            r_state  <= S_FIN;
                        end else if (i_elem_count > r_cap) begin
                            r_status <= ST_OVER_CAP;
                            r_state  <= S_FIN;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= S_FL_RD;
                        end
                    end
                end
                S_FL_RD: begin
                    if (r_k >= r_ftotal) begin
                        if (r_total >= (ID_W+1)'(MAX_ENTRIES)) begin
                            r_status <= ST_FULL;
                            r_state  <= S_FIN;
                        end else begin
                            r_cur       <= '0;
                            r_have_last <= 1'b0;
                            r_found     <= 1'b0;
                            r_i         <= '0;
                            r_pv        <= 1'b0;
                            r_state     <= S_GAP;
                        end
                    end else begin
                        r_state <= S_FL_E;
                    end
                end
                S_FL_E: begin
                    r_e     <= r_fo_rd;
                    r_state <= S_FL_CHK;
                end
                S_FL_CHK: begin
                    if (((ID_W+1)'(r_e) < r_total) && !r_in_use[r_e]
                        && (r_size_rd >= r_cnt)) begin
                        r_ent         <= r_e;
                        r_off         <= r_off_rd;
                        r_reused      <= 1'b1;
                        r_in_use[r_e] <= 1'b1;
                        r_state       <= S_SHIFT;
                    end else begin
                        r_k     <= w_k1;
                        r_state <= S_FL_RD;
                    end
                end
                S_SHIFT: begin
                    // close the hole left by the reused slot
                    if (w_k1 < r_ftotal) begin
                        r_state <= S_SH_W;
                    end else begin
                        r_ftotal <= r_ftotal - 1'b1;
                        r_state  <= S_MUL;
                    end
                end
                S_SH_W: begin
                    r_k     <= w_k1;
                    r_state <= S_SHIFT;
                end
                S_GAP: begin
                    // one pass: find the smallest range key above the last one
                    if (r_i < r_total) begin
                        r_i    <= r_i + 1'b1;
                        r_pidx <= r_i[ID_W-1:0];
                        r_pv   <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv && r_in_use[r_pidx] && (!r_have_last || w_key > r_last)
                        && (!r_found || w_key < r_best)) begin
                        r_best  <= w_key;
                        r_found <= 1'b1;
                    end
                    if (!r_pv && r_i >= r_total) begin
                        r_state <= S_GAP_ST;
                    end
                end
                S_GAP_ST: begin
                    if (!r_found || (w_best_s >= w_need_end)) begin
                        r_state <= S_PLACE;
                    end else begin
                        if (w_best_e > r_cur) begin
                            r_cur <= w_best_e;
                        end
                        r_last      <= r_best;
                        r_have_last <= 1'b1;
                        r_found     <= 1'b0;
                        r_i         <= '0;
                        r_state     <= S_GAP;
                    end
                end
                S_PLACE: begin
                    if (w_ent_we) begin
                        r_ent                         <= r_total[ID_W-1:0];
                        r_off                         <= r_cur[CW-1:0];
                        r_in_use[r_total[ID_W-1:0]]   <= 1'b1;
                        r_total                       <= r_total + 1'b1;
                        r_state                       <= S_MUL;
                    end else begin
                        r_status <= ST_NO_SPACE;
                        r_state  <= S_FIN;
                    end
                end
                S_MUL: begin
                    r_state <= S_MUL_W;
                end
                S_MUL_W: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && w_out_free) begin
            o_status       <= r_status;
            o_tag_out      <= w_ok ? r_tag : '0;
            o_entry_out    <= w_ok ? r_ent : '0;
            o_offset_bytes <= (w_ok && r_cmd == CMD_ALLOC) ? w_prod : '0;
            o_count_out    <= (w_ok && r_cmd == CMD_ALLOC) ? r_cnt : '0;
            o_reused       <= w_ok && r_reused;
        end
    end

endmodule
